### rtl/qrr_pkg.sv
// Shared types, codes and constants of the quorum replicated register.
// Used by qrr_csr, qrr_ctrl, qrr_dpath and quorum_replicated_register.
package qrr_pkg;

   // Sizes
   localparam int NODE_COUNT  = 4;
   localparam int NODE_IDX_W  = $clog2(NODE_COUNT);
   localparam int VALUE_W     = 32;
   localparam int COUNTER_W   = 32;
   localparam int WRITER_W    = 16;
   localparam int WEIGHT_W    = 8;
   localparam int WSUM_W      = WEIGHT_W + NODE_IDX_W;
   localparam int KIND_W      = 2;
   localparam int MODE_W      = 2;
   localparam int LEVEL_W     = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Policy constants
   localparam logic [VALUE_W-1:0] TOP_SECRET_LIMIT = VALUE_W'(900000);
   localparam logic [LEVEL_W-1:0] TOP_CLEARANCE    = LEVEL_W'(3);
   localparam logic [WSUM_W-1:0]  WEIGHT_THRESHOLD = WSUM_W'(4);
   localparam logic [NODE_IDX_W:0] MAJORITY_HALF   = (NODE_IDX_W + 1)'(NODE_COUNT / 2);

   // Operation kinds
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   // Quorum rules
   localparam logic [MODE_W-1:0] MODE_MAJORITY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GRID     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLEARANCE     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PARITY        = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_PERMITTED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_MONOTONIC = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_REGRESSION    = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_QUORUM_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NODE0_WEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NODE1_WEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_NODE2_WEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NODE3_WEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WRITER_IDENT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CLEARANCE    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_WRITE_PERMIT = 3'd7;

   // Input item
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [VALUE_W-1:0]    data_value;
      logic [NODE_COUNT-1:0] approval_mask;
   } req_type;

   // Result item
   typedef struct packed {
      logic [VALUE_W-1:0]  result_value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [MODE_W-1:0]                   quorum_mode;
      logic [NODE_COUNT-1:0][WEIGHT_W-1:0] node_weight;
      logic [WRITER_W-1:0]                 writer_ident;
      logic [LEVEL_W-1:0]                  clearance_level;
      logic                                write_permit;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic decide;
      logic step_scan;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic out_free;
   } sts_type;

   // Controller states
   typedef enum logic [3:0] {
      CS_IDLE    = 4'b0001,
      CS_DECIDE  = 4'b0010,
      CS_SCAN    = 4'b0100,
      CS_RESPOND = 4'b1000
   } ctrl_state_type;

endpackage

### rtl/qrr_csr.sv
// Configuration registers of the quorum replicated register.
// Depends on qrr_pkg for register indexes and the cfg_type struct.
module qrr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qrr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qrr_pkg::CSR_DATA_W-1:0]   csr_data,
   output qrr_pkg::cfg_type                 cfg
);

   qrr_pkg::cfg_type cfg_ff;
   qrr_pkg::cfg_type cfg_in;
   logic             write_en;

   // Always take writes
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            qrr_pkg::REG_QUORUM_MODE: begin
               cfg_in.quorum_mode = csr_data[qrr_pkg::MODE_W-1:0];
            end
            qrr_pkg::REG_NODE0_WEIGHT: begin
               cfg_in.node_weight[0] = csr_data[qrr_pkg::WEIGHT_W-1:0];
            end
            qrr_pkg::REG_NODE1_WEIGHT: begin
               cfg_in.node_weight[1] = csr_data[qrr_pkg::WEIGHT_W-1:0];
            end
            qrr_pkg::REG_NODE2_WEIGHT: begin
               cfg_in.node_weight[2] = csr_data[qrr_pkg::WEIGHT_W-1:0];
            end
            qrr_pkg::REG_NODE3_WEIGHT: begin
               cfg_in.node_weight[3] = csr_data[qrr_pkg::WEIGHT_W-1:0];
            end
            qrr_pkg::REG_WRITER_IDENT: begin
               cfg_in.writer_ident = csr_data[qrr_pkg::WRITER_W-1:0];
            end
            qrr_pkg::REG_CLEARANCE: begin
               cfg_in.clearance_level = csr_data[qrr_pkg::LEVEL_W-1:0];
            end
            qrr_pkg::REG_WRITE_PERMIT: begin
               cfg_in.write_permit = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold the registers, load reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quorum_mode     <= qrr_pkg::MODE_MAJORITY;
         cfg_ff.node_weight[0]  <= qrr_pkg::WEIGHT_W'(3);
         cfg_ff.node_weight[1]  <= qrr_pkg::WEIGHT_W'(1);
         cfg_ff.node_weight[2]  <= qrr_pkg::WEIGHT_W'(1);
         cfg_ff.node_weight[3]  <= qrr_pkg::WEIGHT_W'(1);
         cfg_ff.writer_ident    <= qrr_pkg::WRITER_W'(100);
         cfg_ff.clearance_level <= qrr_pkg::TOP_CLEARANCE;
         cfg_ff.write_permit    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/qrr_ctrl.sv
// Controller state machine of the quorum replicated register.
// Depends on qrr_pkg for command, status and state types.
module qrr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qrr_pkg::sts_type  sts,
   output qrr_pkg::cmd_type  cmd
);

   qrr_pkg::ctrl_state_type state_ff;
   qrr_pkg::ctrl_state_type state_in;

   // Take an item only when idle
   assign req_stall = (state_ff != qrr_pkg::CS_IDLE);

   // Sequence one item: decide, optional node scan, respond
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         qrr_pkg::CS_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = qrr_pkg::CS_DECIDE;
            end
         end
         qrr_pkg::CS_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_scan ? qrr_pkg::CS_SCAN : qrr_pkg::CS_RESPOND;
         end
         qrr_pkg::CS_SCAN: begin
            cmd.step_scan = 1'b1;
            if (sts.scan_last) begin
               state_in = qrr_pkg::CS_RESPOND;
            end
         end
         qrr_pkg::CS_RESPOND: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = qrr_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = qrr_pkg::CS_IDLE;
         end
      endcase
   end

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qrr_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/qrr_dpath.sv
// Datapath of the quorum replicated register: node store, read cache,
// node scan, write checks and the result register. Depends on qrr_pkg.
module qrr_dpath (
   input  logic              clock,
   input  logic              reset,
   input  qrr_pkg::cmd_type  cmd,
   output qrr_pkg::sts_type  sts,
   input  qrr_pkg::cfg_type  cfg,
   input  qrr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qrr_pkg::rsp_type  rsp_data
);

   localparam int NC = qrr_pkg::NODE_COUNT;

   // Item and scan registers
   qrr_pkg::req_type                     item_ff;
   qrr_pkg::req_type                     item_in;
   logic [qrr_pkg::STATUS_W-1:0]         pre_status_ff;
   logic [qrr_pkg::STATUS_W-1:0]         pre_status_in;
   logic [qrr_pkg::NODE_IDX_W-1:0]       idx_ff;
   logic [qrr_pkg::NODE_IDX_W-1:0]       idx_in;
   logic [qrr_pkg::VALUE_W-1:0]          best_value_ff;
   logic [qrr_pkg::VALUE_W-1:0]          best_value_in;
   logic [qrr_pkg::COUNTER_W-1:0]        best_counter_ff;
   logic [qrr_pkg::COUNTER_W-1:0]        best_counter_in;
   logic [qrr_pkg::WRITER_W-1:0]         best_writer_ff;
   logic [qrr_pkg::WRITER_W-1:0]         best_writer_in;
   logic [qrr_pkg::COUNTER_W-1:0]        max_counter_ff;
   logic [qrr_pkg::COUNTER_W-1:0]        max_counter_in;

   // Node store and cache
   logic [NC-1:0][qrr_pkg::VALUE_W-1:0]   node_value_ff;
   logic [NC-1:0][qrr_pkg::VALUE_W-1:0]   node_value_in;
   logic [NC-1:0][qrr_pkg::COUNTER_W-1:0] node_counter_ff;
   logic [NC-1:0][qrr_pkg::COUNTER_W-1:0] node_counter_in;
   logic [NC-1:0][qrr_pkg::WRITER_W-1:0]  node_writer_ff;
   logic [NC-1:0][qrr_pkg::WRITER_W-1:0]  node_writer_in;
   logic [qrr_pkg::VALUE_W-1:0]           cache_value_ff;
   logic [qrr_pkg::VALUE_W-1:0]           cache_value_in;
   logic [qrr_pkg::COUNTER_W-1:0]         cache_counter_ff;
   logic [qrr_pkg::COUNTER_W-1:0]         cache_counter_in;
   logic [qrr_pkg::WRITER_W-1:0]          cache_writer_ff;
   logic [qrr_pkg::WRITER_W-1:0]          cache_writer_in;
   logic                                  cache_warm_ff;
   logic                                  cache_warm_in;

   // Result register
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   qrr_pkg::rsp_type                      rsp_data_ff;
   qrr_pkg::rsp_type                      rsp_data_in;

   // Combinational helpers
   logic [qrr_pkg::STATUS_W-1:0]          pre_status;
   logic [qrr_pkg::VALUE_W-1:0]           scan_value;
   logic [qrr_pkg::COUNTER_W-1:0]         scan_counter;
   logic [qrr_pkg::WRITER_W-1:0]          scan_writer;
   logic                                  scan_better;
   logic [qrr_pkg::NODE_IDX_W:0]          approve_count;
   logic [qrr_pkg::WSUM_W-1:0]            weight_sum;
   logic                                  grid_ok;
   logic                                  quorum;
   logic [qrr_pkg::COUNTER_W-1:0]         stamp_counter;
   logic                                  err_mono;
   logic                                  err_regress;
   logic [qrr_pkg::STATUS_W-1:0]          final_status;
   logic [qrr_pkg::VALUE_W-1:0]           final_result;
   logic [NC-1:0]                         mask;
   logic                                  out_free;

   assign mask      = item_ff.approval_mask;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Run the permit, clearance and parity checks in order
   always_comb begin
      if (item_ff.kind == qrr_pkg::KIND_CLEAR) begin
         pre_status = qrr_pkg::STATUS_OK;
      end else if (item_ff.kind == qrr_pkg::KIND_WRITE && !cfg.write_permit) begin
         pre_status = qrr_pkg::STATUS_NOT_PERMITTED;
      end else if (item_ff.data_value > qrr_pkg::TOP_SECRET_LIMIT &&
                   cfg.clearance_level < qrr_pkg::TOP_CLEARANCE) begin
         pre_status = qrr_pkg::STATUS_CLEARANCE;
      end else if (item_ff.kind == qrr_pkg::KIND_WRITE &&
                   cfg.quorum_mode == qrr_pkg::MODE_GRID && item_ff.data_value[0]) begin
         pre_status = qrr_pkg::STATUS_PARITY;
      end else begin
         pre_status = qrr_pkg::STATUS_OK;
      end
   end

   // Status towards the controller
   always_comb begin
      sts.need_scan = (pre_status == qrr_pkg::STATUS_OK) &&
                      ((item_ff.kind == qrr_pkg::KIND_READ && !cache_warm_ff) ||
                       item_ff.kind == qrr_pkg::KIND_WRITE);
      sts.scan_last = (idx_ff == qrr_pkg::NODE_IDX_W'(NC - 1));
      sts.out_free  = out_free;
   end

   // Compare the scanned node with the best so far
   assign scan_value   = node_value_ff[idx_ff];
   assign scan_counter = node_counter_ff[idx_ff];
   assign scan_writer  = node_writer_ff[idx_ff];
   assign scan_better  = (scan_counter > best_counter_ff) ||
                         (scan_counter == best_counter_ff && scan_writer > best_writer_ff);

   // Evaluate the quorum rules
   always_comb begin
      approve_count = '0;
      weight_sum    = '0;
      for (int i = 0; i < NC; i++) begin
         if (mask[i]) begin
            approve_count = approve_count + (qrr_pkg::NODE_IDX_W + 1)'(1);
            weight_sum    = weight_sum + qrr_pkg::WSUM_W'(cfg.node_weight[i]);
         end
      end
      grid_ok = ((mask[0] & mask[1]) | (mask[2] & mask[3])) &
                ((mask[0] & mask[2]) | (mask[1] & mask[3]));
      case (cfg.quorum_mode)
         qrr_pkg::MODE_MAJORITY: quorum = approve_count > qrr_pkg::MAJORITY_HALF;
         qrr_pkg::MODE_GRID:     quorum = grid_ok;
         qrr_pkg::MODE_WEIGHTED: quorum = weight_sum >= qrr_pkg::WEIGHT_THRESHOLD;
         default:                quorum = 1'b0;
      endcase
   end

   // Check counter monotonicity and value regression on approving nodes
   assign stamp_counter = max_counter_ff + qrr_pkg::COUNTER_W'(1);
   always_comb begin
      err_mono    = 1'b0;
      err_regress = 1'b0;
      for (int i = 0; i < NC; i++) begin
         if (mask[i] && !(stamp_counter > node_counter_ff[i])) begin
            err_mono = 1'b1;
         end
         if (mask[i] && item_ff.data_value < node_value_ff[i]) begin
            err_regress = 1'b1;
         end
      end
   end

   // Form the result of the item
   always_comb begin
      final_status = pre_status_ff;
      final_result = '0;
      case (item_ff.kind)
         qrr_pkg::KIND_READ: begin
            if (pre_status_ff == qrr_pkg::STATUS_OK) begin
               final_result = cache_warm_ff ? cache_value_ff : best_value_ff;
            end
         end
         qrr_pkg::KIND_EVAL: begin
            if (pre_status_ff == qrr_pkg::STATUS_OK) begin
               final_result = qrr_pkg::VALUE_W'(quorum);
            end
         end
         qrr_pkg::KIND_WRITE: begin
            if (pre_status_ff != qrr_pkg::STATUS_OK) begin
               final_status = pre_status_ff;
            end else if (err_mono) begin
               final_status = qrr_pkg::STATUS_NOT_MONOTONIC;
            end else if (err_regress) begin
               final_status = qrr_pkg::STATUS_REGRESSION;
            end else begin
               final_status = qrr_pkg::STATUS_OK;
               final_result = item_ff.data_value;
            end
         end
         default: begin
            final_status = qrr_pkg::STATUS_OK;
         end
      endcase
   end

   // Next values of item, scan and state registers
   always_comb begin
      item_in          = item_ff;
      pre_status_in    = pre_status_ff;
      idx_in           = idx_ff;
      best_value_in    = best_value_ff;
      best_counter_in  = best_counter_ff;
      best_writer_in   = best_writer_ff;
      max_counter_in   = max_counter_ff;
      node_value_in    = node_value_ff;
      node_counter_in  = node_counter_ff;
      node_writer_in   = node_writer_ff;
      cache_value_in   = cache_value_ff;
      cache_counter_in = cache_counter_ff;
      cache_writer_in  = cache_writer_ff;
      cache_warm_in    = cache_warm_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;

      // Latch the accepted item
      if (cmd.load_item) begin
         item_in = req_data;
      end

      // Hold the early checks, restart the scan
      if (cmd.decide) begin
         pre_status_in   = pre_status;
         idx_in          = '0;
         best_value_in   = '0;
         best_counter_in = '0;
         best_writer_in  = '0;
         max_counter_in  = '0;
      end

      // Visit one node per cycle
      if (cmd.step_scan) begin
         idx_in = idx_ff + qrr_pkg::NODE_IDX_W'(1);
         if (scan_better) begin
            best_value_in   = scan_value;
            best_counter_in = scan_counter;
            best_writer_in  = scan_writer;
         end
         if (scan_counter > max_counter_ff) begin
            max_counter_in = scan_counter;
         end
      end

      // Deliver the result and update state
      if (cmd.commit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_value = final_result;
         rsp_data_in.status       = final_status;
         case (item_ff.kind)
            qrr_pkg::KIND_CLEAR: begin
               node_value_in   = '0;
               node_counter_in = '0;
               node_writer_in  = '0;
            end
            qrr_pkg::KIND_READ: begin
               if (pre_status_ff == qrr_pkg::STATUS_OK && !cache_warm_ff) begin
                  cache_value_in   = best_value_ff;
                  cache_counter_in = best_counter_ff;
                  cache_writer_in  = best_writer_ff;
                  cache_warm_in    = 1'b1;
               end
            end
            qrr_pkg::KIND_WRITE: begin
               if (final_status == qrr_pkg::STATUS_OK) begin
                  for (int i = 0; i < NC; i++) begin
                     if (mask[i]) begin
                        node_value_in[i]   = item_ff.data_value;
                        node_counter_in[i] = stamp_counter;
                        node_writer_in[i]  = cfg.writer_ident;
                     end
                  end
                  cache_value_in   = item_ff.data_value;
                  cache_counter_in = stamp_counter;
                  cache_writer_in  = cfg.writer_ident;
                  cache_warm_in    = 1'b1;
               end
            end
            default: begin
               cache_warm_in = cache_warm_ff;
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      pre_status_ff   <= pre_status_in;
      best_value_ff   <= best_value_in;
      best_counter_ff <= best_counter_in;
      best_writer_ff  <= best_writer_in;
      max_counter_ff  <= max_counter_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff           <= '0;
         node_value_ff    <= '0;
         node_counter_ff  <= '0;
         node_writer_ff   <= '0;
         cache_value_ff   <= '0;
         cache_counter_ff <= '0;
         cache_writer_ff  <= '0;
         cache_warm_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         idx_ff           <= idx_in;
         node_value_ff    <= node_value_in;
         node_counter_ff  <= node_counter_in;
         node_writer_ff   <= node_writer_in;
         cache_value_ff   <= cache_value_in;
         cache_counter_ff <= cache_counter_in;
         cache_writer_ff  <= cache_writer_in;
         cache_warm_ff    <= cache_warm_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

endmodule

### rtl/quorum_replicated_register.sv
// Quorum replicated register: four timestamped nodes and a read cache.
// Each item is accepted in IDLE, then passes DECIDE and RESPOND; a write or a
// cold read also scans the four nodes in SCAN, one node per cycle through a
// shared comparator. No new item is taken until RESPOND commits the result.
// Synchronous active-high reset empties nodes and cache, loads register defaults.
module quorum_replicated_register (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  qrr_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output qrr_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qrr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qrr_pkg::CSR_DATA_W-1:0]   csr_data
);

   qrr_pkg::cfg_type cfg;
   qrr_pkg::cmd_type cmd;
   qrr_pkg::sts_type sts;

   // Configuration registers
   qrr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Sequencer
   qrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Node store, checks and result register
   qrr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/quorum_replicated_register_tb.sv
// Self-checking testbench for quorum_replicated_register: directed table, then random phases.
// Predicts each result from its own copy of the node, cache and register state, unless a directed row fixes it.
// Depends on qrr_pkg and the quorum_replicated_register RTL.
module quorum_replicated_register_tb;
   import qrr_pkg::*;

   // Unused rule: quorum never holds, no parity rule on writes
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 200;
   localparam int REPORT_LIMIT = 10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   quorum_replicated_register uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Predicted copy of registers and state
   logic [MODE_W-1:0]    mode_cfg;
   logic [WEIGHT_W-1:0]  weight_cfg [NODE_COUNT];
   logic [WRITER_W-1:0]  writer_cfg;
   logic [LEVEL_W-1:0]   clearance_cfg;
   logic                 permit_cfg;
   logic [VALUE_W-1:0]   replica_value  [NODE_COUNT];
   logic [COUNTER_W-1:0] replica_count  [NODE_COUNT];
   logic [WRITER_W-1:0]  replica_writer [NODE_COUNT];
   logic [VALUE_W-1:0]   cached_data;
   logic [COUNTER_W-1:0] cached_count;
   logic [WRITER_W-1:0]  cached_writer;
   logic                 cache_warm;

   rsp_type     pending_results [$];
   int unsigned mismatch_count = 0;
   logic        quiet = 1'b0;
   int unsigned stall_left = 0;

   // Directed stimulus: a register write or an item, with an optional fixed result
   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      logic [KIND_W-1:0]      kind;
      logic [VALUE_W-1:0]     value;
      logic [NODE_COUNT-1:0]  mask;
      logic                   typed;
      logic [VALUE_W-1:0]     want_value;
      logic [STATUS_W-1:0]    want_status;
   } step_row_type;

   step_row_type directed_steps [0:40] = '{
      // cold read of empty nodes, then majority extremes
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b1, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0000, 1'b1, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b1111, 1'b1, 32'd1, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0111, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0011, 1'b0, 32'd0, STATUS_OK},
      // largest value everywhere, then a regression
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'hFFFF_FFFF, 4'b1111,
        1'b1, 32'hFFFF_FFFF, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd5, 4'b0001, 1'b1, 32'd0, STATUS_REGRESSION},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
      // clear keeps the cache; empty mask still stamps the cache
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_CLEAR, 32'hFFFF_FFFF, 4'b1111, 1'b1, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd900001, 4'b0101, 1'b0, 32'd0, STATUS_OK},
      // writes refused
      '{1'b1, REG_WRITE_PERMIT, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd7, 4'b1111,
        1'b1, 32'd0, STATUS_NOT_PERMITTED},
      '{1'b1, REG_WRITE_PERMIT, 16'd1, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      // clearance below top level, either side of the limit
      '{1'b1, REG_CLEARANCE, 16'd2, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_READ, 32'd900001, 4'b0000,
        1'b1, 32'd0, STATUS_CLEARANCE},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd900000, 4'b1111, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'hFFFF_FFFF, 4'b1111,
        1'b1, 32'd0, STATUS_CLEARANCE},
      '{1'b1, REG_CLEARANCE, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_READ, 32'd900000, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b1, REG_CLEARANCE, 16'd3, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      // grid rule and parity
      '{1'b1, REG_QUORUM_MODE, 16'(MODE_GRID), KIND_READ, 32'd0, 4'b0000,
        1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd900003, 4'b1111,
        1'b1, 32'd0, STATUS_PARITY},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b1001, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0111, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd900010, 4'b1010, 1'b0, 32'd0, STATUS_OK},
      // weighted rule, reset weights then extreme weights
      '{1'b1, REG_QUORUM_MODE, 16'(MODE_WEIGHTED), KIND_READ, 32'd0, 4'b0000,
        1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0001, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0011, 1'b0, 32'd0, STATUS_OK},
      '{1'b1, REG_NODE0_WEIGHT, 16'd255, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b1, REG_NODE1_WEIGHT, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b1, REG_NODE2_WEIGHT, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b1, REG_NODE3_WEIGHT, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b0001, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b1110, 1'b0, 32'd0, STATUS_OK},
      // unused rule with the largest writer id
      '{1'b1, REG_WRITER_IDENT, 16'hFFFF, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK},
      '{1'b1, REG_QUORUM_MODE, 16'(MODE_UNUSED), KIND_READ, 32'd0, 4'b0000,
        1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_EVAL, 32'd0, 4'b1111, 1'b1, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_WRITE, 32'd900011, 4'b1111, 1'b0, 32'd0, STATUS_OK},
      '{1'b0, REG_QUORUM_MODE, 16'd0, KIND_READ, 32'd0, 4'b0000, 1'b0, 32'd0, STATUS_OK}
   };

   // Load register defaults and empty the nodes and cache
   task automatic reset_replicas();
      mode_cfg      = MODE_MAJORITY;
      weight_cfg[0] = 8'd3;
      weight_cfg[1] = 8'd1;
      weight_cfg[2] = 8'd1;
      weight_cfg[3] = 8'd1;
      writer_cfg    = 16'd100;
      clearance_cfg = TOP_CLEARANCE;
      permit_cfg    = 1'b1;
      for (int n = 0; n < NODE_COUNT; n++) begin
         replica_value[n]  = '0;
         replica_count[n]  = '0;
         replica_writer[n] = '0;
      end
      cached_data   = '0;
      cached_count  = '0;
      cached_writer = '0;
      cache_warm    = 1'b0;
   endtask

   function automatic logic quorum_met(logic [NODE_COUNT-1:0] mask);
      int unsigned weight_sum;
      weight_sum = 0;
      for (int n = 0; n < NODE_COUNT; n++)
         if (mask[n]) weight_sum += weight_cfg[n];
      case (mode_cfg)
         MODE_MAJORITY: return $countones(mask) > NODE_COUNT / 2;
         MODE_GRID:     return ((mask[0] && mask[1]) || (mask[2] && mask[3])) &&
                               ((mask[0] && mask[2]) || (mask[1] && mask[3]));
         MODE_WEIGHTED: return weight_sum >= WEIGHT_THRESHOLD;
         default:       return 1'b0;
      endcase
   endfunction

   // Advance the predicted state by one item and return its result
   function automatic rsp_type replica_step(req_type item);
      rsp_type              res;
      logic [COUNTER_W-1:0] top_count;
      logic [COUNTER_W-1:0] next_count;
      res.result_value = '0;
      res.status       = STATUS_OK;
      if (item.kind == KIND_CLEAR) begin
         for (int n = 0; n < NODE_COUNT; n++) begin
            replica_value[n]  = '0;
            replica_count[n]  = '0;
            replica_writer[n] = '0;
         end
      end else if (item.kind == KIND_WRITE && !permit_cfg) begin
         res.status = STATUS_NOT_PERMITTED;
      end else if (item.data_value > TOP_SECRET_LIMIT && clearance_cfg < TOP_CLEARANCE) begin
         res.status = STATUS_CLEARANCE;
      end else if (item.kind == KIND_WRITE && mode_cfg == MODE_GRID && item.data_value[0]) begin
         res.status = STATUS_PARITY;
      end else if (item.kind == KIND_READ) begin
         // cold cache: take the newest node, ties to the higher writer
         if (!cache_warm) begin
            cached_data   = '0;
            cached_count  = '0;
            cached_writer = '0;
            for (int n = 0; n < NODE_COUNT; n++) begin
               if (replica_count[n] > cached_count ||
                   (replica_count[n] == cached_count && replica_writer[n] > cached_writer)) begin
                  cached_data   = replica_value[n];
                  cached_count  = replica_count[n];
                  cached_writer = replica_writer[n];
               end
            end
            cache_warm = 1'b1;
         end
         res.result_value = cached_data;
      end else if (item.kind == KIND_EVAL) begin
         res.result_value = VALUE_W'(quorum_met(item.approval_mask));
      end else begin
         top_count = '0;
         for (int n = 0; n < NODE_COUNT; n++)
            if (replica_count[n] > top_count) top_count = replica_count[n];
         next_count = top_count + 1'b1;
         for (int n = 0; n < NODE_COUNT; n++)
            if (item.approval_mask[n] && !(next_count > replica_count[n]))
               res.status = STATUS_NOT_MONOTONIC;
         for (int n = 0; n < NODE_COUNT; n++)
            if (res.status == STATUS_OK && item.approval_mask[n] &&
                item.data_value < replica_value[n])
               res.status = STATUS_REGRESSION;
         if (res.status == STATUS_OK) begin
            for (int n = 0; n < NODE_COUNT; n++) begin
               if (item.approval_mask[n]) begin
                  replica_value[n]  = item.data_value;
                  replica_count[n]  = next_count;
                  replica_writer[n] = writer_cfg;
               end
            end
            cached_data      = item.data_value;
            cached_count     = next_count;
            cached_writer    = writer_cfg;
            cache_warm       = 1'b1;
            res.result_value = item.data_value;
         end
      end
      return res;
   endfunction

   // Mostly no gap, some short, a few long; none in quiet stretches
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (quiet || roll < 55) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40) return VALUE_W'($urandom_range(1000));
      if (roll < 70) return $urandom();
      return TOP_SECRET_LIMIT - 3 + $urandom_range(6);
   endfunction

   // Writes mostly climb above the highest node value so they get past the checks
   function automatic req_type random_item();
      req_type            item;
      int unsigned        roll;
      logic [VALUE_W-1:0] floor_value;
      roll               = $urandom_range(99);
      item.approval_mask = NODE_COUNT'($urandom_range(15));
      item.data_value    = pick_value();
      if (roll < 20) begin
         item.kind = KIND_READ;
      end else if (roll < 45) begin
         item.kind = KIND_EVAL;
      end else if (roll < 95) begin
         item.kind = KIND_WRITE;
         if ($urandom_range(99) < 80) begin
            floor_value = '0;
            for (int n = 0; n < NODE_COUNT; n++)
               if (replica_value[n] > floor_value) floor_value = replica_value[n];
            item.data_value = floor_value + $urandom_range(2000);
            if (mode_cfg == MODE_GRID && $urandom_range(9) != 0) item.data_value[0] = 1'b0;
         end
      end else begin
         item.kind = KIND_CLEAR;
      end
      return item;
   endfunction

   // Offer one item after a random gap; hold it until accepted
   task automatic push_item(req_type item, logic typed, rsp_type fixed);
      int unsigned gap;
      rsp_type     want;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      want = replica_step(item);
      if (typed) want = fixed;
      pending_results.push_back(want);
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic await_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_QUORUM_MODE:  mode_cfg      = data[MODE_W-1:0];
         REG_NODE0_WEIGHT: weight_cfg[0] = data[WEIGHT_W-1:0];
         REG_NODE1_WEIGHT: weight_cfg[1] = data[WEIGHT_W-1:0];
         REG_NODE2_WEIGHT: weight_cfg[2] = data[WEIGHT_W-1:0];
         REG_NODE3_WEIGHT: weight_cfg[3] = data[WEIGHT_W-1:0];
         REG_WRITER_IDENT: writer_cfg    = data[WRITER_W-1:0];
         REG_CLEARANCE:    clearance_cfg = data[LEVEL_W-1:0];
         REG_WRITE_PERMIT: permit_cfg    = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
      if (mismatch_count < REPORT_LIMIT)
         $display("%s: got 0x%08h, expected 0x%08h", what, got, want);
      mismatch_count++;
   endtask

   // Result side: random stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result_value", rsp_data.result_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", rsp_data.result_value, want.result_value);
            if (rsp_data.status !== want.status)
               report_mismatch("status", VALUE_W'(rsp_data.status), VALUE_W'(want.status));
         end
      end
   end

   initial begin
      req_type     item;
      rsp_type     fixed;
      int unsigned roll;
      reset_replicas();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_csr) begin
            await_results();
            set_register(directed_steps[i].reg_index, directed_steps[i].reg_data);
         end else begin
            item.kind          = directed_steps[i].kind;
            item.data_value    = directed_steps[i].value;
            item.approval_mask = directed_steps[i].mask;
            fixed.result_value = directed_steps[i].want_value;
            fixed.status       = directed_steps[i].want_status;
            push_item(item, directed_steps[i].typed, fixed);
         end
      end

      // Random phases, each under fresh register settings
      fixed = '0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         await_results();
         quiet = (phase % 4 == 3);
         set_register(REG_QUORUM_MODE, CSR_DATA_W'(phase % 4));
         for (int n = 0; n < NODE_COUNT; n++) begin
            roll = $urandom_range(99);
            set_register(REG_NODE0_WEIGHT + CSR_INDEX_W'(n),
                         roll < 25 ? 16'd0 : roll < 45 ? 16'd255 :
                         CSR_DATA_W'($urandom_range(4)));
         end
         set_register(REG_WRITER_IDENT, phase == 0 ? 16'd0 : phase == 1 ? 16'hFFFF :
                                        CSR_DATA_W'($urandom_range(16'hFFFF)));
         set_register(REG_CLEARANCE, phase == 2 ? 16'd0 : $urandom_range(99) < 70 ?
                                     CSR_DATA_W'(TOP_CLEARANCE) :
                                     CSR_DATA_W'($urandom_range(3)));
         set_register(REG_WRITE_PERMIT, phase == 5 ? 16'd0 : 16'd1);
         for (int k = 0; k < PHASE_ITEMS; k++)
            push_item(random_item(), 1'b0, fixed);
      end

      await_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("quorum_replicated_register: match");
      else
         $display("quorum_replicated_register: mismatch");
      $finish;
   end

   // Stop a hung run
   initial begin
      #4000000;
      $display("quorum_replicated_register: mismatch");
      $finish;
   end

endmodule
